FILE: src/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg: shared types and constants for the decimal text parser
// Holds the sequencer states, status codes, character codes and the
// control and status bundles passed between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package dtf_pkg;

    localparam int TICKS_W = 63;
    localparam int STATUS_W = 2;
    localparam int FRAC_W = 6;
    localparam int TDEC_W = 5;
    localparam int CHAR_W = 8;

    localparam logic [FRAC_W-1:0] BASE_DECIMALS = 6'd2;
    localparam logic [FRAC_W-1:0] FRAC_MAX = 6'd63;

    localparam logic [CHAR_W-1:0] CHAR_DOT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

    localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PRECISION = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_CHECK,
        ST_SCALE,
        ST_EMIT
    } dtf_state_t;

    // Conditions seen by the sequencer.
    typedef struct packed {
        logic in_valid;
        logic last;
        logic prec_err;
        logic scale_done;
        logic out_free;
    } dtf_status_t;

    // Controls issued by the sequencer.
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic char_step;
        logic check_load;
        logic zero_step;
        logic finish;
    } dtf_ctrl_t;

endpackage

FILE: src/dtf_mac10.sv
// ----------------------------------------------------------------------------
// dtf_mac10: shared multiply-by-ten-and-add unit
// Computes value*10 + digit with shifts and adds and flags a result that
// no longer fits in the value width.
// ----------------------------------------------------------------------------
module dtf_mac10 #(
    parameter int VALUE_BITS = 63
) (
    input  logic [VALUE_BITS-1:0] value,
    input  logic [3:0]            digit,
    output logic [VALUE_BITS-1:0] result,
    output logic                  overflow
);
    localparam int WIDE_W = VALUE_BITS + 4;

    logic [WIDE_W-1:0] sum;

    // 10x = 8x + 2x; the sum of a full value and nine fits in four extra bits.
    assign sum = {1'b0, value, 3'b000}
               + {3'b000, value, 1'b0}
               + WIDE_W'(digit);

    assign result = sum[VALUE_BITS-1:0];
    assign overflow = |sum[WIDE_W-1:VALUE_BITS];

endmodule

FILE: src/dtf_ctrl.sv
// ----------------------------------------------------------------------------
// dtf_ctrl: sequencer for the decimal text parser
// Steps each character through capture and update; on the final character
// it runs the check, the scaling loop unless the precision check fails, and the result hand-off.
// ----------------------------------------------------------------------------
module dtf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  dtf_pkg::dtf_status_t stat,
    output dtf_pkg::dtf_ctrl_t   ctl
);
    import dtf_pkg::*;

    dtf_state_t state_reg;
    dtf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                ctl.char_step = 1'b1;
                state_next = stat.last ? ST_CHECK : ST_IDLE;
            end
            ST_CHECK:
            begin
                ctl.check_load = 1'b1;
                state_next = stat.prec_err ? ST_EMIT : ST_SCALE;
            end
            ST_SCALE:
            begin
                if (stat.scale_done)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    ctl.zero_step = 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    ctl.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/decimal_text_to_fixed_ticks.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_ticks: ASCII price text to fixed-point tick count
// Accumulates decimal digits one character per transaction and, on the
// final character, scales the value to 2 + tick_decimals implied decimals.
// ----------------------------------------------------------------------------
// Each character is captured, then passed once through the shared
//   multiply-by-ten unit; no new character is taken until that is done.
// After the final character come the check, one zero-digit scale pass per
//   missing fraction digit (none on a precision error), then the emit step.
// Reset (rst_n, asynchronous, active low) clears the text state, the
//   tick_decimals register and the result valid flag.
module decimal_text_to_fixed_ticks #(
    parameter int VALUE_BITS = 63
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dtf_pkg::CHAR_W-1:0]          character,
    input  logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dtf_pkg::TDEC_W-1:0]          tick_decimals,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dtf_pkg::TICKS_W-1:0]         ticks,
    output logic [dtf_pkg::STATUS_W-1:0]        status
);
    import dtf_pkg::*;

    // Captured character of the transaction being worked on.
    logic [CHAR_W-1:0]     char_reg;
    logic                  last_reg;

    // Text state.
    logic [VALUE_BITS-1:0] accum_reg;
    logic [VALUE_BITS-1:0] accum_next;
    logic                  ovf_reg;
    logic                  ovf_next;
    logic                  dot_reg;
    logic                  dot_next;
    logic [FRAC_W-1:0]     frac_reg;
    logic [FRAC_W-1:0]     frac_next;
    logic                  prec_reg;
    logic                  prec_next;
    logic [FRAC_W-1:0]     count_reg;
    logic [FRAC_W-1:0]     count_next;

    logic [TDEC_W-1:0]     tdec_reg;

    // Output register; it lets the parser start the next text while a result
    // still waits to be taken.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [TICKS_W-1:0]    ticks_reg;
    logic [TICKS_W-1:0]    ticks_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;

    logic                  is_dot;
    logic                  is_digit;
    logic [FRAC_W-1:0]     required;
    logic [FRAC_W-1:0]     actual;
    logic [3:0]            mac_digit;
    logic [VALUE_BITS-1:0] mac_result;
    logic                  mac_ovf;
    logic [STATUS_W-1:0]   final_status;

    dtf_status_t           stat;
    dtf_ctrl_t             ctl;

    // Character decode. The low nibble of an ASCII digit is its value.
    assign is_dot = (char_reg == CHAR_DOT);
    assign is_digit = (char_reg >= CHAR_ZERO) && (char_reg <= CHAR_NINE);

    // Required fraction digits are two plus the register; a text with no
    // dot counts as having no fraction digits at all.
    assign required = BASE_DECIMALS + FRAC_W'(tdec_reg);
    assign actual = dot_reg ? frac_reg : '0;

    // Scaling passes feed a zero digit through the same unit.
    assign mac_digit = ctl.char_step ? char_reg[3:0] : 4'd0;

    dtf_mac10 #(
        .VALUE_BITS (VALUE_BITS)
    ) u_mac10 (
        .value    (accum_reg),
        .digit    (mac_digit),
        .result   (mac_result),
        .overflow (mac_ovf)
    );

    assign stat.in_valid = in_valid;
    assign stat.last = last_reg;
    assign stat.prec_err = (actual > required);
    assign stat.scale_done = (count_reg >= required);
    assign stat.out_free = !out_valid_reg || out_ready;

    dtf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // A precision error wins over an overflow.
    assign final_status = prec_reg ? STATUS_PRECISION :
                          ovf_reg  ? STATUS_OVERFLOW  : STATUS_OK;

    always_comb
    begin
        accum_next = accum_reg;
        ovf_next = ovf_reg;
        dot_next = dot_reg;
        frac_next = frac_reg;
        prec_next = prec_reg;
        count_next = count_reg;
        out_valid_next = out_valid_reg;
        ticks_next = ticks_reg;
        status_next = status_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Once the value has overflowed it stays frozen.
        if ((ctl.char_step && is_digit) || ctl.zero_step)
        begin
            if (!ovf_reg)
            begin
                if (mac_ovf)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    accum_next = mac_result;
                end
            end
        end

        if (ctl.char_step)
        begin
            if (is_dot)
            begin
                dot_next = 1'b1;
                frac_next = '0;
            end
            else if (is_digit && dot_reg && (frac_reg != FRAC_MAX))
            begin
                frac_next = frac_reg + 1'b1;
            end
        end

        if (ctl.check_load)
        begin
            prec_next = stat.prec_err;
            count_next = actual;
        end

        if (ctl.zero_step)
        begin
            count_next = count_reg + 1'b1;
        end

        if (ctl.finish)
        begin
            out_valid_next = 1'b1;
            status_next = final_status;
            ticks_next = (final_status == STATUS_OK) ? TICKS_W'(accum_reg) : '0;
            accum_next = '0;
            ovf_next = 1'b0;
            dot_next = 1'b0;
            frac_next = '0;
            prec_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            ovf_reg <= 1'b0;
            dot_reg <= 1'b0;
            frac_reg <= '0;
            prec_reg <= 1'b0;
            count_reg <= '0;
            tdec_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            accum_reg <= accum_next;
            ovf_reg <= ovf_next;
            dot_reg <= dot_next;
            frac_reg <= frac_next;
            prec_reg <= prec_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                tdec_reg <= tick_decimals;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            char_reg <= character;
            last_reg <= last;
        end
        ticks_reg <= ticks_next;
        status_reg <= status_next;
    end

    // The configuration register is always writable.
    assign cfg_ready = 1'b1;
    assign in_ready = ctl.in_ready;
    assign out_valid = out_valid_reg;
    assign ticks = ticks_reg;
    assign status = status_reg;

endmodule

FILE: src/dtf_checker.sv
// ----------------------------------------------------------------------------
// dtf_checker: port-level checks for the decimal text parser
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module dtf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic [dtf_pkg::TICKS_W-1:0]    ticks,
    input logic [dtf_pkg::STATUS_W-1:0]   status
);
    import dtf_pkg::*;

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ticks) && $stable(status))
        else $error("result changed while stalled");

    // Only the three defined status codes are ever reported.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK) || (status == STATUS_PRECISION)
                      || (status == STATUS_OVERFLOW))
        else $error("undefined status code");

    // An error result carries no tick count.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> (ticks == '0))
        else $error("nonzero ticks with error status");

    // Input ready drops right after a character is accepted.
    a_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");

endmodule

bind decimal_text_to_fixed_ticks dtf_checker u_dtf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ticks     (ticks),
    .status    (status)
);
